// ===== hdl/autowin_pkg.sv =====
package autowin_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int GRAY_BITS  = 8;
    localparam int NUM_BITS   = PIXEL_BITS + GRAY_BITS;
    localparam int REM_BITS   = PIXEL_BITS + 1;
    localparam int CNT_BITS   = $clog2(GRAY_BITS);

    localparam logic [GRAY_BITS-1:0] GRAY_MAX  = {GRAY_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0]  CNT_LAST  = CNT_BITS'(GRAY_BITS - 1);

    typedef logic [PIXEL_BITS-1:0] t_pix;
    typedef logic [GRAY_BITS-1:0]  t_gray;
    typedef logic [NUM_BITS-1:0]   t_num;
    typedef logic [REM_BITS-1:0]   t_rem;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

// ===== hdl/autowin_if.sv =====
interface autowin_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic        frame_start;
    logic [15:0] pixel;

    modport source (output valid, output kind, output frame_start, output pixel, input ready);
    modport sink   (input valid, input kind, input frame_start, input pixel, output ready);
endinterface

interface autowin_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] gray;
    logic       flat;

    modport source (output valid, output gray, output flat, input ready);
    modport sink   (input valid, input gray, input flat, output ready);
endinterface

// ===== hdl/auto_window_16_to_8_top.sv =====
// Statistics request: taken while idle, updates min/max, gives no result.
// Mapping request: passes through a setup state, the restoring divider's quotient
// steps (one quotient bit per step) and a result state; flat, below-min or saturated
// pixels skip the divider. No new request is taken until the result is written out.
// A finished result sits in the output register while the next request is taken.
// Synchronous active-low reset: min = all ones, max = 0, output empty, idle.
module auto_window_16_to_8_top
    import autowin_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    autowin_in_if.sink           i_in,
    autowin_out_if.source        o_out
);

    t_state                r_state, n_state;
    t_pix                  r_min, n_min;
    t_pix                  r_max, n_max;
    t_pix                  r_pix, n_pix;
    t_rem                  r_rem, n_rem;
    t_gray                 r_quo, n_quo;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic                  r_flat, n_flat;
    logic                  r_out_valid, n_out_valid;
    t_gray                 r_gray, n_gray;
    logic                  r_out_flat, n_out_flat;

    t_pix   w_in_pix;
    t_pix   w_span;
    t_pix   w_diff;
    t_num   w_num;
    t_rem   w_trial;
    logic   w_take;

    assign w_in_pix = i_in.pixel[PIXEL_BITS-1:0];
    assign w_span   = r_max - r_min;
    assign w_diff   = r_pix - r_min;
    // diff * 255 as a shift and subtract
    assign w_num    = {w_diff, {GRAY_BITS{1'b0}}} - {{GRAY_BITS{1'b0}}, w_diff};
    assign w_trial  = {r_rem[PIXEL_BITS-1:0], r_quo[GRAY_BITS-1]};
    assign w_take   = i_in.valid && (r_state == ST_IDLE);

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.gray  = r_gray;
    assign o_out.flat  = r_out_flat;

    always_comb begin
        n_state     = r_state;
        n_min       = r_min;
        n_max       = r_max;
        n_pix       = r_pix;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_flat      = r_flat;
        n_out_valid = r_out_valid;
        n_gray      = r_gray;
        n_out_flat  = r_out_flat;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    if (i_in.kind) begin
                        n_pix   = w_in_pix;
                        n_state = ST_PREP;
                    end else if (i_in.frame_start) begin
                        n_min = w_in_pix;
                        n_max = w_in_pix;
                    end else begin
                        if (w_in_pix < r_min) n_min = w_in_pix;
                        if (w_in_pix > r_max) n_max = w_in_pix;
                    end
                end
            end
            ST_PREP: begin
                n_flat = 1'b0;
                n_cnt  = '0;
                if (r_max <= r_min) begin
                    n_flat  = 1'b1;
                    n_quo   = '0;
                    n_state = ST_DONE;
                end else if (r_pix <= r_min) begin
                    n_quo   = '0;
                    n_state = ST_DONE;
                end else if (w_diff >= w_span) begin
                    n_quo   = GRAY_MAX;
                    n_state = ST_DONE;
                end else begin
                    // high part is below span, so the quotient fits in 8 bits
                    n_rem   = {1'b0, w_num[NUM_BITS-1:GRAY_BITS]};
                    n_quo   = w_num[GRAY_BITS-1:0];
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                // shift one dividend bit in, subtract when it fits, shift quotient bit in
                if (w_trial >= {1'b0, w_span}) begin
                    n_rem = w_trial - {1'b0, w_span};
                    n_quo = {r_quo[GRAY_BITS-2:0], 1'b1};
                end else begin
                    n_rem = w_trial;
                    n_quo = {r_quo[GRAY_BITS-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) n_state = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register frees up
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_gray      = r_quo;
                    n_out_flat  = r_flat;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_min       <= '1;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_min       <= n_min;
            r_max       <= n_max;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix      <= n_pix;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_flat     <= n_flat;
        r_gray     <= n_gray;
        r_out_flat <= n_out_flat;
    end

endmodule

// ===== hdl/autowin_chk.sv =====
module autowin_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_kind,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_gray,
    input logic       i_out_flat
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_flat |-> i_out_gray == 8'd0)
        else $error("flat result with nonzero gray");

    // a mapping request occupies the divider
    a_map_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_kind |=> !i_in_ready)
        else $error("request taken while mapping in progress");

    // statistics requests never create a result
    a_stat_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_kind && !i_out_valid |=> !i_out_valid)
        else $error("result appeared after statistics request");

endmodule

bind auto_window_16_to_8_top autowin_chk u_autowin_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_kind   (i_in.kind),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_gray  (o_out.gray),
    .i_out_flat  (o_out.flat)
);

// ===== dv/tb_auto_window_16_to_8_top.sv =====
module tb_auto_window_16_to_8_top
    import autowin_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_STATS = 1'b0;
    localparam logic KIND_MAP   = 1'b1;
    localparam int   PHASE_ITEMS = 640;
    localparam int   TAIL_CYCLES = 24;

    typedef struct packed {
        t_gray gray;
        logic  flat;
    } t_stretch;

    typedef struct packed {
        logic  kind;
        logic  frame_start;
        t_pix  pixel;
        logic  typed;
        t_gray gray;
        logic  flat;
    } t_dir_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic rcv_ready = 1'b0;

    autowin_in_if  req_if ();
    autowin_out_if res_if ();

    assign res_if.ready = rcv_ready;

    auto_window_16_to_8_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // running frame statistics as the block should hold them
    t_pix     lo_seen = '1;
    t_pix     hi_seen = '0;
    t_stretch expected_gray_q[$];

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int err_count    = 0;
    int n_stats      = 0;
    int n_maps       = 0;
    int n_flat       = 0;
    int n_frames     = 0;
    int n_checked    = 0;

    // kind, frame_start, pixel, typed, gray, flat
    t_dir_row dir_rows [0:24] = '{
        '{KIND_MAP,   1'b0, 16'h0000, 1'b1, 8'd0,   1'b1},
        '{KIND_MAP,   1'b0, 16'hFFFF, 1'b1, 8'd0,   1'b1},
        '{KIND_MAP,   1'b1, 16'h1234, 1'b1, 8'd0,   1'b1},
        '{KIND_STATS, 1'b1, 16'h0000, 1'b0, 8'd0,   1'b0},
        '{KIND_STATS, 1'b0, 16'hFFFF, 1'b0, 8'd0,   1'b0},
        '{KIND_MAP,   1'b0, 16'h0000, 1'b1, 8'd0,   1'b0},
        '{KIND_MAP,   1'b0, 16'hFFFF, 1'b1, 8'd255, 1'b0},
        '{KIND_MAP,   1'b0, 16'h8000, 1'b0, 8'd0,   1'b0},
        '{KIND_MAP,   1'b0, 16'h0101, 1'b0, 8'd0,   1'b0},
        '{KIND_STATS, 1'b1, 16'd1000, 1'b0, 8'd0,   1'b0},
        '{KIND_STATS, 1'b0, 16'd1000, 1'b0, 8'd0,   1'b0},
        '{KIND_MAP,   1'b0, 16'd1000, 1'b1, 8'd0,   1'b1},
        '{KIND_MAP,   1'b0, 16'd5,    1'b1, 8'd0,   1'b1},
        '{KIND_STATS, 1'b0, 16'd2000, 1'b0, 8'd0,   1'b0},
        '{KIND_MAP,   1'b0, 16'd500,  1'b1, 8'd0,   1'b0},
        '{KIND_MAP,   1'b0, 16'd1000, 1'b1, 8'd0,   1'b0},
        '{KIND_MAP,   1'b0, 16'd2000, 1'b1, 8'd255, 1'b0},
        '{KIND_MAP,   1'b0, 16'd1500, 1'b0, 8'd0,   1'b0},
        '{KIND_MAP,   1'b0, 16'd60000, 1'b1, 8'd255, 1'b0},
        '{KIND_MAP,   1'b1, 16'd2000, 1'b1, 8'd255, 1'b0},
        '{KIND_STATS, 1'b1, 16'hFFFF, 1'b0, 8'd0,   1'b0},
        '{KIND_STATS, 1'b0, 16'hFFFE, 1'b0, 8'd0,   1'b0},
        '{KIND_MAP,   1'b0, 16'hFFFE, 1'b1, 8'd0,   1'b0},
        '{KIND_MAP,   1'b0, 16'hFFFF, 1'b1, 8'd255, 1'b0},
        '{KIND_MAP,   1'b0, 16'h0000, 1'b1, 8'd0,   1'b0}
    };

    function automatic t_stretch stretch_pixel(t_pix pix);
        logic [31:0] scaled;
        t_stretch    r;
        r.gray = '0;
        r.flat = 1'b0;
        if (hi_seen <= lo_seen) begin
            r.flat = 1'b1;
        end else if (pix > lo_seen) begin
            scaled = (32'(pix) - 32'(lo_seen)) * 32'd255 / (32'(hi_seen) - 32'(lo_seen));
            r.gray = (scaled > 32'(GRAY_MAX)) ? GRAY_MAX : t_gray'(scaled);
        end
        return r;
    endfunction

    function automatic void update_range(logic frame_start, t_pix pix);
        if (frame_start) begin
            lo_seen = pix;
            hi_seen = pix;
        end else begin
            if (pix < lo_seen) lo_seen = pix;
            if (pix > hi_seen) hi_seen = pix;
        end
    endfunction

    // Present one request and hold it until taken; called right after a rising edge.
    task automatic send_request(input logic kind, input logic frame_start, input t_pix pix,
                                input logic typed = 1'b0, input t_gray tgray = '0,
                                input logic tflat = 1'b0);
        t_stretch want;
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
        req_if.valid       <= 1'b1;
        req_if.kind        <= kind;
        req_if.frame_start <= frame_start;
        req_if.pixel       <= pix;
        do @(posedge i_clk); while (!req_if.ready);
        if (kind == KIND_STATS) begin
            update_range(frame_start, pix);
            n_stats++;
        end else begin
            want = stretch_pixel(pix);
            if (typed) begin
                want.gray = tgray;
                want.flat = tflat;
            end
            if (want.flat) n_flat++;
            expected_gray_q.push_back(want);
            n_maps++;
        end
    endtask

    // Hold off the sender until every pending result is back.
    task automatic drain_results();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_gray_q.size() > 0);
    endtask

    // One frame: statistics pass then mapping pass, with occasional broken sequences.
    task automatic run_frame();
        int   shape;
        int   spread;
        int   lo;
        int   hi;
        int   n_stat;
        int   n_map;
        logic restart;
        t_pix pix;
        shape = $urandom_range(0, 3);
        case (shape)
            0: begin
                spread = 65535;
            end
            1: begin
                spread = $urandom_range(0, 15);
            end
            2: begin
                spread = 0;
            end
            default: begin
                spread = $urandom_range(16, 4095);
            end
        endcase
        lo = $urandom_range(0, 65535 - spread);
        hi = lo + spread;
        n_stat  = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        n_map   = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        restart = ($urandom_range(0, 19) != 0);
        for (int i = 0; i < n_stat; i++) begin
            send_request(KIND_STATS, (i == 0 && restart) || ($urandom_range(0, 49) == 0),
                         t_pix'($urandom_range(hi, lo)));
        end
        for (int i = 0; i < n_map; i++) begin
            pix = ($urandom_range(0, 4) == 0) ? t_pix'($urandom) : t_pix'($urandom_range(hi, lo));
            send_request(KIND_MAP, 1'($urandom_range(0, 1)), pix);
        end
        if ($urandom_range(0, 9) == 0) begin
            send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), t_pix'($urandom));
        end
        n_frames++;
    endtask

    always @(posedge i_clk) begin
        t_stretch want;
        if (!i_rst_n) begin
            rcv_ready <= 1'b0;
        end else begin
            rcv_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            if (res_if.valid && res_if.ready) begin
                if (expected_gray_q.size() == 0) begin
                    $error("result with no request pending: gray %0d flat %0b",
                           res_if.gray, res_if.flat);
                    err_count++;
                end else begin
                    want = expected_gray_q.pop_front();
                    n_checked++;
                    if (res_if.gray !== want.gray) begin
                        $error("gray mismatch: expected %0d, actual %0d", want.gray, res_if.gray);
                        err_count++;
                    end
                    if (res_if.flat !== want.flat) begin
                        $error("flat mismatch: expected %0b, actual %0b", want.flat, res_if.flat);
                        err_count++;
                    end
                end
            end
        end
    end

    initial begin
        req_if.valid       <= 1'b0;
        req_if.kind        <= KIND_STATS;
        req_if.frame_start <= 1'b0;
        req_if.pixel       <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle_pct = 8;
        rcv_idle_pct = 78;
        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].kind, dir_rows[i].frame_start, dir_rows[i].pixel,
                         dir_rows[i].typed, dir_rows[i].gray, dir_rows[i].flat);
        end
        drain_results();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    snd_idle_pct = 8;
                    rcv_idle_pct = 78;
                end
                1: begin
                    snd_idle_pct = 78;
                    rcv_idle_pct = 8;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            for (int start = n_stats + n_maps; n_stats + n_maps - start < PHASE_ITEMS;) begin
                run_frame();
                if ($urandom_range(0, 24) == 0) drain_results();
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d requests in %0d random frames: %0d statistics, %0d mapped",
                 n_stats + n_maps, n_frames, n_stats, n_maps);
        $display("checked %0d results, %0d of them flat, %0d errors",
                 n_checked, n_flat, err_count);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
